[sv/qsl_pkg.sv]
// Shared types, constants and arithmetic helpers for the quaternion step limiter.
`timescale 1ns / 1ps

package qsl_pkg;

    // Q2.30 unity and the register index codes.
    localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
    localparam logic [30:0] ONE_Q30_U31  = 31'h4000_0000;
    localparam logic        REG_COS_HALF = 1'b0;
    localparam logic        REG_SIN_HALF = 1'b1;
    localparam logic [30:0] COS_HALF_RST = 31'd1068377587;
    localparam logic [30:0] SIN_HALF_RST = 31'd107195315;

    // Pipeline depths of the square root and divider chains.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // Input beat.
    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] target_w;
        logic signed [31:0] current_x;
        logic signed [31:0] current_y;
        logic signed [31:0] current_z;
        logic signed [31:0] current_w;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic signed [31:0] command_x;
        logic signed [31:0] command_y;
        logic signed [31:0] command_z;
        logic signed [31:0] command_w;
        logic               was_limited;
        logic               bad_target;
    } result_t;

    // Item context carried alongside the limit computation.
    typedef struct packed {
        logic [3:0][31:0] c;
        logic [3:0][31:0] d;
        logic             bad;
        logic             cand;
    } ctx_t;

    // State of one square root iteration.
    typedef struct packed {
        logic [63:0] s;
        logic [63:0] r;
    } sqrt_t;

    // Result of one restoring division step.
    typedef struct packed {
        logic [31:0] rem;
        logic        qbit;
    } dstep_t;

    // One digit of the bitwise integer square root.
    function automatic sqrt_t isqrt_step(input sqrt_t cur, input logic [63:0] bitv);
        logic [63:0] trial;
        sqrt_t       nxt;
        trial = cur.r + bitv;
        if (cur.s >= trial)
        begin
            nxt.s = cur.s - trial;
            nxt.r = (cur.r >> 1) + bitv;
        end
        else
        begin
            nxt.s = cur.s;
            nxt.r = cur.r >> 1;
        end
        return nxt;
    endfunction

    // One quotient bit of a restoring division.
    function automatic dstep_t div_step(input logic [31:0] rem, input logic nbit,
                                        input logic [31:0] den);
        logic [32:0] t;
        dstep_t      o;
        t = {rem, nbit};
        if (t >= {1'b0, den})
        begin
            t      = t - {1'b0, den};
            o.qbit = 1'b1;
        end
        else
        begin
            o.qbit = 1'b0;
        end
        o.rem = t[31:0];
        return o;
    endfunction

    // Q60 to Q30, rounding half away from zero.
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic        [65:0] m;
        logic        [65:0] sh;
        logic signed [35:0] q;
        m  = v[65] ? 66'(-v) : 66'(v);
        sh = (m + (66'd1 << 29)) >> 30;
        q  = $signed(sh[35:0]);
        return v[65] ? -q : q;
    endfunction

    // Clamp to [-1.0, 1.0] in Q2.30.
    function automatic logic signed [31:0] sat30(input logic signed [35:0] v);
        if (v > 36'sd1073741824)
        begin
            return 32'sd1073741824;
        end
        else if (v < -36'sd1073741824)
        begin
            return -32'sd1073741824;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

endpackage

[sv/quaternion_step_limiter_core.sv]
// Top level of the quaternion step limiter: fully pipelined, one beat per cycle.
//
//   channel   handshake            payload
//   input     start (busy low)     item   (in_item_t)
//   result    done strobe          result (result_t)
//   config    wr_en                wr_index, wr_data
//
// A new beat may be started in every cycle; busy is always low.
// A beat's result is strobed on done after the capture register,
// two 69-stage normalizers, a 32-stage square root and a 31-stage divider
// for the limited axis, plus the product and rounding stages.
// Reset clears the valid bits and loads the default limit registers.
// The result strobe cannot be held off, so nothing in the pipe ever stalls.
`timescale 1ns / 1ps

module quaternion_step_limiter_core
    import qsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        done,
    output result_t     result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [30:0] wr_data
);

    localparam int TOP_LEN = 5 + SQRT_STEPS + 2 + DIV_STEPS + 4;

    // Limit registers.
    logic [30:0] cos_reg, sin_reg;
    logic [30:0] cl_w, sl_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= COS_HALF_RST;
            sin_reg <= SIN_HALF_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_COS_HALF: cos_reg <= wr_data;
                REG_SIN_HALF: sin_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign cl_w = (cos_reg > ONE_Q30_U31) ? ONE_Q30_U31 : cos_reg;
    assign sl_w = (sin_reg > ONE_Q30_U31) ? ONE_Q30_U31 : sin_reg;

    assign busy = 1'b0;

    // Stage A: capture the beat, clamp the current orientation.
    logic [3:0][31:0] tin_c, cin_c;
    logic             va_reg;
    logic [3:0][34:0] ta_reg;
    logic [3:0][31:0] ca_reg;

    always_comb
    begin
        tin_c[0] = item.target_x;
        tin_c[1] = item.target_y;
        tin_c[2] = item.target_z;
        tin_c[3] = item.target_w;
        cin_c[0] = item.current_x;
        cin_c[1] = item.current_y;
        cin_c[2] = item.current_z;
        cin_c[3] = item.current_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            ta_reg[i] <= {{3{tin_c[i][31]}}, tin_c[i]};
            ca_reg[i] <= sat30($signed({{4{cin_c[i][31]}}, cin_c[i]}));
        end
    end

    // Target normalization, current orientation rides along.
    logic             n1_valid, n1_ok;
    logic [3:0][31:0] n1_u;
    logic [127:0]     n1_sb;
    logic [3:0][31:0] n1_c;

    qsl_norm4 #(
        .SB_W (128)
    ) u_norm_target (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (va_reg),
        .in_vec    (ta_reg),
        .in_sb     (ca_reg),
        .out_valid (n1_valid),
        .out_vec   (n1_u),
        .out_ok    (n1_ok),
        .out_sb    (n1_sb)
    );

    assign n1_c = n1_sb;

    // Valid bits from the first normalizer to the second.
    logic vl_reg [TOP_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOP_LEN; k++)
            begin
                vl_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vl_reg[0] <= n1_valid;
            for (int k = 1; k < TOP_LEN; k++)
            begin
                vl_reg[k] <= vl_reg[k-1];
            end
        end
    end

    // Stage B: all products u(i) * c(j).
    logic signed [63:0] pb_reg [4][4];
    logic [3:0][31:0]   cb_reg;
    logic               badb_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pb_reg[i][j] <= $signed(n1_u[i]) * $signed(n1_c[j]);
            end
        end
        cb_reg   <= n1_c;
        badb_reg <= ~n1_ok;
    end

    // Stage C: difference rotation sums; the scalar sum is also the dot product.
    logic signed [65:0] sc_reg [4];
    logic [3:0][31:0]   cc_reg;
    logic               badc_reg;

    always_ff @(posedge clk)
    begin
        sc_reg[3] <= pb_reg[3][3] + pb_reg[0][0] + pb_reg[1][1] + pb_reg[2][2];
        sc_reg[0] <= pb_reg[0][3] - pb_reg[3][0] - pb_reg[1][2] + pb_reg[2][1];
        sc_reg[1] <= pb_reg[1][3] - pb_reg[3][1] - pb_reg[2][0] + pb_reg[0][2];
        sc_reg[2] <= pb_reg[2][3] - pb_reg[3][2] - pb_reg[0][1] + pb_reg[1][0];
        cc_reg    <= cb_reg;
        badc_reg  <= badb_reg;
    end

    // Stage D: round, flip to the near hemisphere, clamp.
    logic signed [35:0] rd_c [4];
    logic [3:0][31:0]   dd_reg;
    logic [3:0][31:0]   cd_reg;
    logic               badd_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rd_c[i] = rnd30(sc_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            dd_reg[i] <= sat30(sc_reg[3][65] ? -rd_c[i] : rd_c[i]);
        end
        cd_reg   <= cc_reg;
        badd_reg <= badc_reg;
    end

    // Stage E: limit test and squares of the axis part.
    ctx_t               ctx_e_reg;
    logic [2:0][61:0]   sqd_reg;
    logic signed [63:0] dsq_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsq_c[i] = $signed(dd_reg[i]) * $signed(dd_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_e_reg.c    <= cd_reg;
        ctx_e_reg.d    <= dd_reg;
        ctx_e_reg.bad  <= badd_reg;
        ctx_e_reg.cand <= ($signed(dd_reg[3]) < $signed({1'b0, cl_w}));
        for (int i = 0; i < 3; i++)
        begin
            sqd_reg[i] <= dsq_c[i][61:0];
        end
    end

    // Stage F: squared axis length.
    ctx_t        ctx_f_reg;
    logic [61:0] nvsq_reg;

    always_ff @(posedge clk)
    begin
        ctx_f_reg <= ctx_e_reg;
        nvsq_reg  <= sqd_reg[0] + sqd_reg[1] + sqd_reg[2];
    end

    // Axis length square root.
    sqrt_t tsq_reg    [SQRT_STEPS];
    ctx_t  ctx_sq_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        sqrt_t sq_in;
        ctx_t  cx_in;
        if (k == 0)
        begin : g_first
            assign sq_in = {2'b00, nvsq_reg, 64'd0};
            assign cx_in = ctx_f_reg;
        end
        else
        begin : g_next
            assign sq_in = tsq_reg[k-1];
            assign cx_in = ctx_sq_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            tsq_reg[k]    <= isqrt_step(sq_in, 64'd1 << (62 - 2 * k));
            ctx_sq_reg[k] <= cx_in;
        end
    end

    // Stage G: scale the axis magnitudes by the sine limit.
    ctx_t             ctx_g_reg;
    logic [2:0][61:0] gprod_reg;
    logic [2:0]       gneg_reg;
    logic [31:0]      gnv_reg;
    logic [2:0][30:0] dabs_c;
    ctx_t             ctx_sq_last;

    assign ctx_sq_last = ctx_sq_reg[SQRT_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dabs_c[i] = ctx_sq_last.d[i][31] ? 31'(-$signed(ctx_sq_last.d[i]))
                      : ctx_sq_last.d[i][30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            gprod_reg[i] <= {31'd0, sl_w} * {31'd0, dabs_c[i]};
            gneg_reg[i]  <= ctx_sq_last.d[i][31];
        end
        gnv_reg   <= tsq_reg[SQRT_STEPS-1].r[31:0];
        ctx_g_reg <= ctx_sq_last;
    end

    // Stage H: rounded numerators and first partial remainders.
    ctx_t             ctx_h_reg;
    logic [2:0][31:0] hrem_reg;
    logic [2:0][30:0] hnlo_reg;
    logic [2:0]       hneg_reg;
    logic [31:0]      hden_reg;
    logic [2:0][61:0] hnum_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hnum_c[i] = gprod_reg[i] + {31'd0, gnv_reg[31:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            hrem_reg[i] <= {1'b0, hnum_c[i][61:31]};
            hnlo_reg[i] <= hnum_c[i][30:0];
        end
        hneg_reg  <= gneg_reg;
        hden_reg  <= gnv_reg;
        ctx_h_reg <= ctx_g_reg;
    end

    // Divide by the axis length, one quotient bit per stage.
    logic [2:0][31:0] dv_rem_reg [DIV_STEPS];
    logic [2:0][30:0] dv_nlo_reg [DIV_STEPS];
    logic [2:0][30:0] dv_q_reg   [DIV_STEPS];
    logic [2:0]       dv_neg_reg [DIV_STEPS];
    logic [31:0]      dv_den_reg [DIV_STEPS];
    ctx_t             dv_ctx_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [2:0][31:0] rem_in;
        logic [2:0][30:0] nlo_in;
        logic [2:0][30:0] q_in;
        logic [2:0]       neg_in;
        logic [31:0]      den_in;
        ctx_t             cx_in;
        dstep_t [2:0]     st;
        if (j == 0)
        begin : g_first
            assign rem_in = hrem_reg;
            assign nlo_in = hnlo_reg;
            assign q_in   = '0;
            assign neg_in = hneg_reg;
            assign den_in = hden_reg;
            assign cx_in  = ctx_h_reg;
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[j-1];
            assign nlo_in = dv_nlo_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign neg_in = dv_neg_reg[j-1];
            assign den_in = dv_den_reg[j-1];
            assign cx_in  = dv_ctx_reg[j-1];
        end
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                st[i] = div_step(rem_in[i], nlo_in[i][30], den_in);
            end
        end
        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[j][i] <= st[i].rem;
                dv_nlo_reg[j][i] <= {nlo_in[i][29:0], 1'b0};
                dv_q_reg[j][i]   <= {q_in[i][29:0], st[i].qbit};
            end
            dv_neg_reg[j] <= neg_in;
            dv_den_reg[j] <= den_in;
            dv_ctx_reg[j] <= cx_in;
        end
    end

    // Stage I: pick the limited, identity or unchanged difference rotation.
    ctx_t             ctx_last;
    logic [3:0][31:0] dsel_c;
    logic             lim_c;
    logic [31:0]      qmag_c;
    logic [3:0][31:0] di_reg;
    logic [3:0][31:0] ci_reg;
    logic             badi_reg, limi_reg;

    assign ctx_last = dv_ctx_reg[DIV_STEPS-1];

    always_comb
    begin
        dsel_c = ctx_last.d;
        lim_c  = 1'b0;
        qmag_c = '0;
        if (ctx_last.cand)
        begin
            if (dv_den_reg[DIV_STEPS-1] == '0)
            begin
                dsel_c[3] = ONE_Q30;
            end
            else
            begin
                lim_c     = 1'b1;
                dsel_c[3] = {1'b0, cl_w};
                for (int i = 0; i < 3; i++)
                begin
                    qmag_c = (dv_q_reg[DIV_STEPS-1][i] > ONE_Q30_U31) ? ONE_Q30
                           : {1'b0, dv_q_reg[DIV_STEPS-1][i]};
                    dsel_c[i] = dv_neg_reg[DIV_STEPS-1][i] ? 32'(-$signed(qmag_c)) : qmag_c;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        di_reg   <= dsel_c;
        ci_reg   <= ctx_last.c;
        badi_reg <= ctx_last.bad;
        limi_reg <= lim_c;
    end

    // Stage J: all products d(i) * c(j).
    logic signed [63:0] pj_reg [4][4];
    logic [3:0][31:0]   cj_reg;
    logic               badj_reg, limj_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pj_reg[i][j] <= $signed(di_reg[i]) * $signed(ci_reg[j]);
            end
        end
        cj_reg   <= ci_reg;
        badj_reg <= badi_reg;
        limj_reg <= limi_reg;
    end

    // Stage K: sums of the rotation d * c.
    logic signed [65:0] sk_reg [4];
    logic [3:0][31:0]   ck_reg;
    logic               badk_reg, limk_reg;

    always_ff @(posedge clk)
    begin
        sk_reg[3] <= pj_reg[3][3] - pj_reg[0][0] - pj_reg[1][1] - pj_reg[2][2];
        sk_reg[0] <= pj_reg[3][0] + pj_reg[0][3] + pj_reg[1][2] - pj_reg[2][1];
        sk_reg[1] <= pj_reg[3][1] + pj_reg[1][3] + pj_reg[2][0] - pj_reg[0][2];
        sk_reg[2] <= pj_reg[3][2] + pj_reg[2][3] + pj_reg[0][1] - pj_reg[1][0];
        ck_reg    <= cj_reg;
        badk_reg  <= badj_reg;
        limk_reg  <= limj_reg;
    end

    // Stage L: round the product to Q2.30.
    logic [3:0][34:0]   pl_reg;
    logic [129:0]       sbl_reg;
    logic signed [35:0] rp_c [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rp_c[i] = rnd30(sk_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            pl_reg[i] <= rp_c[i][34:0];
        end
        sbl_reg <= {ck_reg, limk_reg, badk_reg};
    end

    // Final renormalization.
    logic             n2_valid, n2_ok;
    logic [3:0][31:0] n2_q;
    logic [129:0]     n2_sb;
    logic [3:0][31:0] n2_c;

    qsl_norm4 #(
        .SB_W (130)
    ) u_norm_command (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vl_reg[TOP_LEN-1]),
        .in_vec    (pl_reg),
        .in_sb     (sbl_reg),
        .out_valid (n2_valid),
        .out_vec   (n2_q),
        .out_ok    (n2_ok),
        .out_sb    (n2_sb)
    );

    assign n2_c = n2_sb[129:2];

    // Result register: fall back to the current orientation when needed.
    logic             done_reg;
    result_t          result_reg;
    logic [3:0][31:0] cmd_c;

    always_comb
    begin
        cmd_c = (n2_sb[0] || !n2_ok) ? n2_c : n2_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= n2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.command_x   <= cmd_c[0];
        result_reg.command_y   <= cmd_c[1];
        result_reg.command_z   <= cmd_c[2];
        result_reg.command_w   <= cmd_c[3];
        result_reg.was_limited <= n2_sb[1] & ~n2_sb[0];
        result_reg.bad_target  <= n2_sb[0];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[sv/qsl_norm4.sv]
// Pipelined normalization of a four-component vector to unit length in Q2.30.
`timescale 1ns / 1ps

module qsl_norm4
    import qsl_pkg::*;
#(
    parameter int SB_W = 128
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [3:0][34:0]      in_vec,
    input  logic [SB_W-1:0]       in_sb,
    output logic                  out_valid,
    output logic [3:0][31:0]      out_vec,
    output logic                  out_ok,
    output logic [SB_W-1:0]       out_sb
);

    localparam int LAT    = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int AN_LEN = SQRT_STEPS + 2;
    localparam int SIDE_W = SB_W + 5;

    // Magnitudes, signs and largest magnitude of the incoming beat.
    logic [3:0][33:0] abs_c;
    logic [3:0]       neg_c;
    logic [33:0]      mx01_c, mx23_c, mx_c;
    logic             zero_c;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg_c[i] = in_vec[i][34];
            abs_c[i] = in_vec[i][34] ? 34'(-$signed(in_vec[i])) : in_vec[i][33:0];
        end
        mx01_c = (abs_c[0] > abs_c[1]) ? abs_c[0] : abs_c[1];
        mx23_c = (abs_c[2] > abs_c[3]) ? abs_c[2] : abs_c[3];
        mx_c   = (mx01_c > mx23_c) ? mx01_c : mx23_c;
        zero_c = (mx_c == '0);
    end

    // Valid bits and the side line of sideband, signs and zero flag.
    logic              vld_reg  [LAT];
    logic [SIDE_W-1:0] side_reg [LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= {in_sb, neg_c, zero_c};
        for (int k = 1; k < LAT - 1; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Stage 1: magnitudes and their maximum.
    logic [3:0][33:0] a1_reg;
    logic [33:0]      m1_reg;

    always_ff @(posedge clk)
    begin
        a1_reg <= abs_c;
        m1_reg <= mx_c;
    end

    // Stage 2: shift all magnitudes so the largest lies in [2^28, 2^30).
    logic [5:0]       pos_c;
    logic [3:0][29:0] an_c;
    logic [3:0][29:0] an2_reg;

    always_comb
    begin
        pos_c = '0;
        for (int b = 0; b < 34; b++)
        begin
            if (m1_reg[b])
            begin
                pos_c = 6'(b);
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (pos_c > 6'd29)
            begin
                an_c[i] = 30'(a1_reg[i] >> (pos_c - 6'd29));
            end
            else if (pos_c < 6'd28)
            begin
                an_c[i] = 30'(a1_reg[i] << (6'd28 - pos_c));
            end
            else
            begin
                an_c[i] = a1_reg[i][29:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        an2_reg <= an_c;
    end

    // Stage 3: squares.
    logic [3:0][59:0] sq3_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq3_reg[i] <= {30'd0, an2_reg[i]} * {30'd0, an2_reg[i]};
        end
    end

    // Stage 4: sum of squares.
    logic [61:0] sum4_reg;

    always_ff @(posedge clk)
    begin
        sum4_reg <= {2'b00, sq3_reg[0]} + {2'b00, sq3_reg[1]}
                  + {2'b00, sq3_reg[2]} + {2'b00, sq3_reg[3]};
    end

    // Shifted magnitudes wait for the root.
    logic [3:0][29:0] an_reg [AN_LEN];

    always_ff @(posedge clk)
    begin
        an_reg[0] <= an2_reg;
        for (int k = 1; k < AN_LEN; k++)
        begin
            an_reg[k] <= an_reg[k-1];
        end
    end

    // Square root, one result bit per stage.
    sqrt_t sq_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        sqrt_t sq_in;
        if (k == 0)
        begin : g_first
            assign sq_in = {2'b00, sum4_reg, 64'd0};
        end
        else
        begin : g_next
            assign sq_in = sq_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            sq_reg[k] <= isqrt_step(sq_in, 64'd1 << (62 - 2 * k));
        end
    end

    // Divider setup: rounded numerator, first partial remainder.
    logic [3:0][31:0] ds_rem_reg;
    logic [3:0][30:0] ds_nlo_reg;
    logic [31:0]      ds_den_reg;
    logic [3:0][60:0] num_c;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            num_c[i] = {1'b0, an_reg[AN_LEN-1][i], 30'd0}
                     + 61'(sq_reg[SQRT_STEPS-1].r[63:1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            ds_rem_reg[i] <= {2'b00, num_c[i][60:31]};
            ds_nlo_reg[i] <= num_c[i][30:0];
        end
        ds_den_reg <= sq_reg[SQRT_STEPS-1].r[31:0];
    end

    // Divider, one quotient bit per stage in each lane.
    logic [3:0][31:0] dv_rem_reg [DIV_STEPS];
    logic [3:0][30:0] dv_nlo_reg [DIV_STEPS];
    logic [3:0][30:0] dv_q_reg   [DIV_STEPS];
    logic [31:0]      dv_den_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [3:0][31:0] rem_in;
        logic [3:0][30:0] nlo_in;
        logic [3:0][30:0] q_in;
        logic [31:0]      den_in;
        dstep_t [3:0]     st;
        if (j == 0)
        begin : g_first
            assign rem_in = ds_rem_reg;
            assign nlo_in = ds_nlo_reg;
            assign q_in   = '0;
            assign den_in = ds_den_reg;
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[j-1];
            assign nlo_in = dv_nlo_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign den_in = dv_den_reg[j-1];
        end
        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                st[i] = div_step(rem_in[i], nlo_in[i][30], den_in);
            end
        end
        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dv_rem_reg[j][i] <= st[i].rem;
                dv_nlo_reg[j][i] <= {nlo_in[i][29:0], 1'b0};
                dv_q_reg[j][i]   <= {q_in[i][29:0], st[i].qbit};
            end
            dv_den_reg[j] <= den_in;
        end
    end

    // Output stage: clamp to one and restore the signs.
    logic [3:0][31:0] mag_c;
    logic [3:0][31:0] out_vec_reg;
    logic             out_ok_reg;
    logic [SB_W-1:0]  out_sb_reg;
    logic [SIDE_W-1:0] side_last;

    assign side_last = side_reg[LAT-2];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag_c[i] = (dv_q_reg[DIV_STEPS-1][i] > ONE_Q30_U31) ? ONE_Q30
                     : {1'b0, dv_q_reg[DIV_STEPS-1][i]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            out_vec_reg[i] <= side_last[1 + i] ? 32'(-$signed(mag_c[i])) : mag_c[i];
        end
        out_ok_reg <= ~side_last[0];
        out_sb_reg <= side_last[SIDE_W-1:5];
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_vec   = out_vec_reg;
    assign out_ok    = out_ok_reg;
    assign out_sb    = out_sb_reg;

endmodule
